### sv/scw_pkg.sv
// Shared types, field layout and opcode constants for the sector write cache.
package scw_pkg;

    localparam int SCW_DEF_ENTRIES = 8;
    localparam int SCW_DEF_WORDS   = 64;

    localparam int OP_W       = 3;
    localparam int SECTOR_W   = 32;
    localparam int WIDX_IN_W  = 6;
    localparam int WORD_W     = 64;
    localparam int OUT_IDX_W  = 6;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;

    localparam int SECTOR_LSB = 0;
    localparam int WIDX_LSB   = SECTOR_LSB + SECTOR_W;
    localparam int DATA_LSB   = WIDX_LSB + WIDX_IN_W;

    localparam logic [SECTOR_W-1:0] NO_SECTOR = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OP_W-1:0] OP_READ      = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY     = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH     = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

    typedef struct packed {
        logic                 last;
        logic [OUT_IDX_W-1:0] index;
        logic [WORD_W-1:0]    word;
        logic                 hit;
        logic                 status;
    } res_t;

endpackage

### sv/scw_out_buf.sv
// Two-entry result queue that decouples the cache core from the output channel.
module scw_out_buf import scw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  res_t       push_data,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       head,
    output logic [1:0] level
);

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign head    = q_reg[rd_ptr_reg];
    assign level   = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != 2'd2 || pop))
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd3) && ((cnt_reg == 2'd1) || (wr_ptr_reg == rd_ptr_reg)))
        else $error("result queue pointers inconsistent with level");

endmodule

### sv/sector_write_cache.sv
// Fully associative sector cache with round-robin replacement, top level.
//
// Usage:
//   Input transactions arrive on s_tvalid/s_tready with the opcode in s_tuser and
//   sector, word index and data word packed in s_tdata. Results leave on
//   m_tvalid/m_tready with status, hit, word and index in m_tdata and m_tlast
//   marking the final result of each input transaction.
//   Tags and valid marks live in flip-flops and are compared in parallel in the
//   accept cycle; sector words live in a single-port-write, single-port-read
//   memory with a registered read output.
//   Write, mark-dirty, flush, flush-all, query and clear each return one result;
//   with m_tready held high one such item is taken per cycle.
//   A read hit returns no single result but sweeps the sector's WORDS_PER_SECTOR
//   words out of the memory in order; the words leave one per cycle while the
//   result queue has room, and input is taken again once the last read has drained.
//   After reset and after a clear, a clearing pass writes zero to all
//   CACHE_ENTRIES * 2**max(1, ceil(log2(WORDS_PER_SECTOR))) memory words (512 by
//   default); no input is taken during it.
//   A stalled receiver fills the two-entry result queue, which then pauses the
//   read sweep and input acceptance without losing or repeating results.
module sector_write_cache import scw_pkg::*; #(
    parameter int CACHE_ENTRIES    = SCW_DEF_ENTRIES,
    parameter int WORDS_PER_SECTOR = SCW_DEF_WORDS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sector[31:0], word_index[37:32], data_word[101:38], zero pad[103:102]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[0], hit[1], out_word[65:2], out_index[71:66]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int EW        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int WW        = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
    localparam int ADDR_W    = EW + WW;
    localparam int MEM_DEPTH = CACHE_ENTRIES * (2 ** WW);
    localparam int WIDX_N    = 2 ** WIDX_IN_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [WW-1:0]     LAST_WORD  = WW'(WORDS_PER_SECTOR - 1);
    localparam logic [EW-1:0]     LAST_ENTRY = EW'(CACHE_ENTRIES - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [SECTOR_W-1:0] tag_reg [CACHE_ENTRIES];
    logic [SECTOR_W-1:0] tag_next [CACHE_ENTRIES];
    logic [EW-1:0]       victim_reg, victim_next;
    logic [EW-1:0]       rd_entry_reg, rd_entry_next;
    logic [WW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                inflight_reg;
    logic [OUT_IDX_W-1:0] rd_idx_reg;
    logic                rd_last_reg;
    logic [WORD_W-1:0]   rdata_reg;

    logic [WORD_W-1:0]   mem [MEM_DEPTH];

    logic [OP_W-1:0]      in_op;
    logic [SECTOR_W-1:0]  in_sector;
    logic [WIDX_IN_W-1:0] in_widx_raw;
    logic [WORD_W-1:0]    in_data;
    logic [WW-1:0]        widx_tbl [WIDX_N];
    logic [WW-1:0]        in_widx;

    logic              hit_any;
    logic [EW-1:0]     hit_idx;
    logic [EW-1:0]     wr_entry;
    logic              accept;
    logic              pop;
    logic [2:0]        occ;
    logic              rd_issue;
    logic [1:0]        buf_level;
    logic              buf_valid;
    res_t              buf_head;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              push_single;
    res_t              single_res;
    res_t              read_res;
    res_t              push_data;
    logic              push;
    logic [WW+OUT_IDX_W-1:0] rd_idx_wide;

    assign in_op       = s_tuser;
    assign in_sector   = s_tdata[SECTOR_LSB +: SECTOR_W];
    assign in_widx_raw = s_tdata[WIDX_LSB +: WIDX_IN_W];
    assign in_data     = s_tdata[DATA_LSB +: WORD_W];

    for (genvar i = 0; i < WIDX_N; i++) begin : g_widx
        assign widx_tbl[i] = WW'(i % WORDS_PER_SECTOR);
    end
    assign in_widx = widx_tbl[in_widx_raw];

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int e = CACHE_ENTRIES - 1; e >= 0; e--) begin
            if (valid_reg[e] && (tag_reg[e] == in_sector)) begin
                hit_any = 1'b1;
                hit_idx = EW'(e);
            end
        end
    end

    assign wr_entry = hit_any ? hit_idx : victim_reg;
    assign pop      = m_tvalid && m_tready;
    assign occ      = {1'b0, buf_level} + {2'b00, inflight_reg};
    assign rd_issue = (state_reg == ST_READ) && ((occ < 3'd2) || ((occ == 3'd2) && pop));
    assign s_tready = (state_reg == ST_IDLE) && !inflight_reg && (buf_level != 2'd2);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        valid_next    = valid_reg;
        tag_next      = tag_reg;
        victim_next   = victim_reg;
        rd_entry_next = rd_entry_reg;
        rd_cnt_next   = rd_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = {rd_entry_reg, rd_cnt_reg};
        push_single   = 1'b0;
        single_res    = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    push_single     = 1'b1;
                    single_res.last = 1'b1;
                    single_res.hit  = hit_any;
                    case (in_op) inside
                        OP_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = {wr_entry, in_widx};
                            mem_wdata = in_data;
                            if (!hit_any) begin
                                tag_next[victim_reg]   = in_sector;
                                valid_next[victim_reg] = 1'b1;
                                victim_next = (victim_reg == LAST_ENTRY) ? '0
                                                                         : victim_reg + 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (hit_any) begin
                                push_single   = 1'b0;
                                state_next    = ST_READ;
                                rd_entry_next = hit_idx;
                                rd_cnt_next   = '0;
                            end else begin
                                single_res.status = 1'b1;
                            end
                        end
                        OP_DIRTY, OP_QUERY: begin
                            single_res.status = (in_op == OP_DIRTY) && !hit_any;
                        end
                        OP_FLUSH: begin
                            single_res.status = !hit_any;
                            if (hit_any) begin
                                valid_next[hit_idx] = 1'b0;
                            end
                        end
                        OP_FLUSH_ALL: begin
                            single_res.hit = 1'b0;
                            valid_next     = '0;
                        end
                        OP_CLEAR: begin
                            single_res.hit = 1'b0;
                            valid_next     = '0;
                            for (int e = 0; e < CACHE_ENTRIES; e++) begin
                                tag_next[e] = NO_SECTOR;
                            end
                            victim_next   = '0;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            push_single = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (rd_issue) begin
                    mem_re      = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == LAST_WORD) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rd_idx_wide = {{OUT_IDX_W{1'b0}}, rd_cnt_reg};

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_idx_reg  <= rd_idx_wide[OUT_IDX_W-1:0];
            rd_last_reg <= (rd_cnt_reg == LAST_WORD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            valid_reg    <= '0;
            victim_reg   <= '0;
            rd_entry_reg <= '0;
            rd_cnt_reg   <= '0;
            inflight_reg <= 1'b0;
            for (int e = 0; e < CACHE_ENTRIES; e++) begin
                tag_reg[e] <= NO_SECTOR;
            end
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            valid_reg    <= valid_next;
            victim_reg   <= victim_next;
            rd_entry_reg <= rd_entry_next;
            rd_cnt_reg   <= rd_cnt_next;
            inflight_reg <= rd_issue;
            tag_reg      <= tag_next;
        end
    end

    always_comb begin
        read_res        = '0;
        read_res.status = 1'b0;
        read_res.hit    = 1'b1;
        read_res.word   = rdata_reg;
        read_res.index  = rd_idx_reg;
        read_res.last   = rd_last_reg;
    end

    assign push      = push_single || inflight_reg;
    assign push_data = inflight_reg ? read_res : single_res;

    scw_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (buf_valid),
        .m_ready   (m_tready),
        .head      (buf_head),
        .level     (buf_level)
    );

    assign m_tvalid = buf_valid;
    assign m_tdata  = {buf_head.index, buf_head.word, buf_head.hit, buf_head.status};
    assign m_tlast  = buf_head.last;

    a_read_enters_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_READ) && hit_any)
            |=> (state_reg == ST_READ) && (rd_cnt_reg == '0))
        else $error("read hit did not start the word sweep");

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_CLEAR))
            |=> (state_reg == ST_CLEAR) && (valid_reg == '0) && (victim_reg == '0))
        else $error("clear did not restart the clearing pass");

    a_read_data_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> !push_single && ($past(state_reg) == ST_READ))
        else $error("read data landed outside a read sweep");

    a_victim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_WRITE) && !hit_any) |-> (victim_reg <= LAST_ENTRY))
        else $error("victim pointer out of range");

endmodule
